// ===== src/lkvt_pkg.sv =====
// Package with the constants and types shared by the linear key/value table.
`timescale 1ns / 1ps

package lkvt_pkg;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned KEY_WIDTH   = 32;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(DEPTH + 1);
  localparam int unsigned ECNT_W      = 5;

  typedef enum logic {
    CmdPut = 1'b0,
    CmdGet = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    StatOk       = 2'd0,
    StatNotFound = 2'd1,
    StatFull     = 2'd2
  } status_e;

endpackage

// ===== src/lkvt_req_if.sv =====
// Interface for the request channel of the linear key/value table.
`timescale 1ns / 1ps

interface lkvt_req_if;
  import lkvt_pkg::*;

  logic                   valid;
  logic                   ready;
  cmd_e                   command;
  logic [KEY_WIDTH-1:0]   lookup_key;
  logic [VALUE_WIDTH-1:0] data_value;

  modport source (output valid, command, lookup_key, data_value, input ready);
  modport sink (input valid, command, lookup_key, data_value, output ready);
endinterface

// ===== src/lkvt_rsp_if.sv =====
// Interface for the response channel of the linear key/value table.
`timescale 1ns / 1ps

interface lkvt_rsp_if;
  import lkvt_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] read_value;
  logic                   key_existed;
  status_e                status;
  logic [ECNT_W-1:0]      entry_count;

  modport source (output valid, read_value, key_existed, status, entry_count, input ready);
  modport sink (input valid, read_value, key_existed, status, entry_count, output ready);
endinterface

// ===== src/lkvt_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module lkvt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/linear_key_value_table_unit.sv =====
// Top level of the linear key/value table: search sequencer over key and value RAMs.
// An accepted item is searched in StScan, its result is held in StHold and then registered into the output.
// Throughput: one item at a time; the key search reads
// one stored key per cycle through the read port of the key RAM.
// A waiting result sits in the output register while the next item is accepted.
// Reset clears the fill count and control state; the RAM contents are not cleared.
`timescale 1ns / 1ps

module linear_key_value_table_unit (
  input  logic clk_i,
  input  logic rst_ni,
  lkvt_req_if.sink   req_i,
  lkvt_rsp_if.source rsp_o
);
  import lkvt_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StHold
  } state_e;

  state_e                 state_q, state_d;
  cmd_e                   cmd_q, cmd_d;
  logic [KEY_WIDTH-1:0]   key_q, key_d;
  logic [VALUE_WIDTH-1:0] val_q, val_d;
  logic [CNT_W-1:0]       fill_q, fill_d;
  logic [CNT_W-1:0]       raddr_q, raddr_d;
  logic [ADDR_W-1:0]      cmp_idx_q, cmp_idx_d;
  logic                   cmp_vld_q, cmp_vld_d;

  logic [VALUE_WIDTH-1:0] res_val_q, res_val_d;
  logic                   res_ex_q, res_ex_d;
  status_e                res_st_q, res_st_d;

  logic                   ovalid_q, ovalid_d;
  logic [VALUE_WIDTH-1:0] oval_q, oval_d;
  logic                   oex_q, oex_d;
  status_e                ost_q, ost_d;
  logic [ECNT_W-1:0]      ocnt_q, ocnt_d;

  logic [KEY_WIDTH-1:0]   key_rdata;
  logic [VALUE_WIDTH-1:0] val_rdata;
  logic                   key_we, val_we;
  logic [ADDR_W-1:0]      waddr;
  logic                   hit, more;

  lkvt_ram #(.WIDTH(KEY_WIDTH), .DEPTH(DEPTH)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (waddr),
    .wdata_i (key_q),
    .raddr_i (raddr_q[ADDR_W-1:0]),
    .rdata_o (key_rdata)
  );

  lkvt_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (waddr),
    .wdata_i (val_q),
    .raddr_i (raddr_q[ADDR_W-1:0]),
    .rdata_o (val_rdata)
  );

  assign req_i.ready       = (state_q == StIdle);
  assign rsp_o.valid       = ovalid_q;
  assign rsp_o.read_value  = oval_q;
  assign rsp_o.key_existed = oex_q;
  assign rsp_o.status      = ost_q;
  assign rsp_o.entry_count = ocnt_q;

  assign hit  = cmp_vld_q && (key_rdata == key_q);
  assign more = (raddr_q < fill_q);

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    key_d     = key_q;
    val_d     = val_q;
    fill_d    = fill_q;
    raddr_d   = raddr_q;
    cmp_idx_d = cmp_idx_q;
    cmp_vld_d = 1'b0;
    res_val_d = res_val_q;
    res_ex_d  = res_ex_q;
    res_st_d  = res_st_q;
    ovalid_d  = ovalid_q && !rsp_o.ready;
    oval_d    = oval_q;
    oex_d     = oex_q;
    ost_d     = ost_q;
    ocnt_d    = ocnt_q;
    key_we    = 1'b0;
    val_we    = 1'b0;
    waddr     = fill_q[ADDR_W-1:0];

    case (state_q)
      StIdle: begin
        if (req_i.valid) begin
          cmd_d   = req_i.command;
          key_d   = req_i.lookup_key;
          val_d   = req_i.data_value;
          raddr_d = '0;
          state_d = StScan;
        end
      end
      StScan: begin
        if (hit) begin
          res_ex_d = 1'b1;
          res_st_d = StatOk;
          state_d  = StHold;
          if (cmd_q == CmdGet) begin
            res_val_d = val_rdata;
          end else begin
            res_val_d = '0;
            val_we    = 1'b1;
            waddr     = cmp_idx_q;
          end
        end else if (more) begin
          cmp_vld_d = 1'b1;
          cmp_idx_d = raddr_q[ADDR_W-1:0];
          raddr_d   = raddr_q + CNT_W'(1);
        end else begin
          res_val_d = '0;
          res_ex_d  = 1'b0;
          state_d   = StHold;
          if (cmd_q == CmdGet) begin
            res_st_d = StatNotFound;
          end else if (fill_q == CNT_W'(DEPTH)) begin
            res_st_d = StatFull;
          end else begin
            res_st_d = StatOk;
            key_we   = 1'b1;
            val_we   = 1'b1;
            fill_d   = fill_q + CNT_W'(1);
          end
        end
      end
      StHold: begin
        if (!ovalid_q || rsp_o.ready) begin
          ovalid_d = 1'b1;
          oval_d   = res_val_q;
          oex_d    = res_ex_q;
          ost_d    = res_st_q;
          ocnt_d   = ECNT_W'(fill_q);
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      fill_q    <= '0;
      cmp_vld_q <= 1'b0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      cmp_vld_q <= cmp_vld_d;
      ovalid_q  <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    key_q     <= key_d;
    val_q     <= val_d;
    raddr_q   <= raddr_d;
    cmp_idx_q <= cmp_idx_d;
    res_val_q <= res_val_d;
    res_ex_q  <= res_ex_d;
    res_st_q  <= res_st_d;
    oval_q    <= oval_d;
    oex_q     <= oex_d;
    ost_q     <= ost_d;
    ocnt_q    <= ocnt_d;
  end

endmodule
